// ===== hw/rtl/htld_pkg.sv =====
// htld_pkg: shared command codes, status codes and the queued command type
// for the in-band Huffman tree load and decode core. No dependencies.
package htld_pkg;

  // command codes, equal to the kind field of an input transaction
  localparam logic [1:0] OP_SHAPE = 2'd0;
  localparam logic [1:0] OP_NAME  = 2'd1;
  localparam logic [1:0] OP_CODE  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_DECODED  = 2'd0;
  localparam logic [1:0] STAT_PHASE    = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;
  localparam logic [1:0] STAT_LOADED   = 2'd3;

  localparam int SYM_W = 8;

  // classified command held in the queue between front and back
  typedef struct packed {
    logic [1:0]       op;
    logic             dbit;  // shape bit or code bit, depending on op
    logic [SYM_W-1:0] sym;
  } cmd_t;

endpackage

// ===== hw/rtl/htld_ram.sv =====
// htld_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module htld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hw/rtl/htld_front.sv =====
// htld_front: accepts input transactions, classifies them into commands and
// holds them in a two-entry queue for the back end. Depends on htld_pkg.
module htld_front import htld_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] shape_bit, [8:1] leaf_symbol, [9] code_bit
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  // classify: keep the one bit that the kind uses
  always_comb begin
    cmd_in.op   = in_tuser;
    cmd_in.dbit = (in_tuser == OP_CODE) ? in_tdata[9] : in_tdata[0];
    cmd_in.sym  = in_tdata[8:1];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid & in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid & q_ready;
  assign q_cmd     = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/htld_back.sv =====
// htld_back: executes queued commands: builds the node table from shape items,
// names leaves, walks the tree for code bits, and drives the result register.
// Depends on htld_pkg and htld_ram.
module htld_back import htld_pkg::*; #(
  parameter int MAX_SYMBOLS = 256,
  parameter int NODE_DEPTH  = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] symbol
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int NW     = $clog2(NODE_DEPTH);
  localparam int SW     = $clog2(MAX_SYMBOLS);
  localparam int CNT_W  = $clog2(NODE_DEPTH + 1);
  localparam int LCW    = $clog2(MAX_SYMBOLS + 1);
  localparam int SUM_W  = ((CNT_W > LCW) ? CNT_W : LCW) + 2;
  localparam int INFO_W = 1 + SYM_W;
  localparam int NODE_W = INFO_W + 2 * NW;

  localparam logic [1:0] PH_SHAPE = 2'd0;
  localparam logic [1:0] PH_NAME  = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHAPE = 3'd1;
  localparam logic [2:0] ST_NAME  = 3'd2;
  localparam logic [2:0] ST_ROOT  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_CODE  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] node_count_r, node_count_nxt;
  logic [CNT_W-1:0] pending_r, pending_nxt;
  logic [LCW-1:0]   leaf_count_r, leaf_count_nxt;
  logic [LCW-1:0]   leaves_named_r, leaves_named_nxt;
  logic             prev_leaf_r, prev_leaf_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] root_r, root_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [SYM_W-1:0] out_symbol_r, out_symbol_nxt;

  // memory ports
  logic              info_we, left_we, right_we, stack_we, list_we;
  logic [NW-1:0]     info_waddr, left_waddr, right_waddr, node_raddr;
  logic [INFO_W-1:0] info_wdata, info_rdata;
  logic [NW-1:0]     left_rdata, right_rdata;
  logic [SW-1:0]     stack_addr, list_waddr, list_raddr;
  logic [NW-1:0]     stack_rdata, list_rdata;
  logic [NW-1:0]     new_node;
  logic [NW-1:0]     walk_next;
  logic [NODE_W-1:0] node_rdata;
  logic              out_free;
  logic              take;
  logic              overflow;

  assign out_free   = ~out_valid_r | out_tready;
  assign q_ready    = (state_r == ST_IDLE) & out_free;
  assign take       = q_valid & q_ready;
  assign new_node   = NW'(node_count_r);
  assign walk_next  = q_cmd.dbit ? cur_r[NW-1:0] : cur_r[2*NW-1:NW];
  assign node_rdata = {info_rdata, left_rdata, right_rdata};
  assign stack_addr = SW'(pending_r - 1'b1);
  assign list_waddr = SW'(leaf_count_r);
  assign list_raddr = SW'(leaves_named_r);
  assign node_raddr = (state_r == ST_ROOT) ? '0 : walk_next;
  assign left_waddr = NW'(node_count_r - 1'b1);
  assign right_waddr = stack_rdata;

  // an internal node is refused if the tree could no longer be finished
  assign overflow =
      (SUM_W'(node_count_r) + SUM_W'(pending_r) + SUM_W'(2) > SUM_W'(NODE_DEPTH)) ||
      (SUM_W'(leaf_count_r) + SUM_W'(pending_r) + SUM_W'(1) > SUM_W'(MAX_SYMBOLS));

  // command sequencer
  always_comb begin
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    node_count_nxt   = node_count_r;
    pending_nxt      = pending_r;
    leaf_count_nxt   = leaf_count_r;
    leaves_named_nxt = leaves_named_r;
    prev_leaf_nxt    = prev_leaf_r;
    cmd_nxt          = cmd_r;
    cur_nxt          = cur_r;
    root_nxt         = root_r;
    out_valid_nxt    = out_valid_r & ~out_tready;
    out_status_nxt   = out_status_r;
    out_symbol_nxt   = out_symbol_r;
    info_we          = 1'b0;
    left_we          = 1'b0;
    right_we         = 1'b0;
    stack_we         = 1'b0;
    list_we          = 1'b0;
    info_waddr       = new_node;
    info_wdata       = {cmd_r.dbit, {SYM_W{1'b0}}};

    case (state_r)
      ST_IDLE: begin
        if (take) begin
          cmd_nxt = q_cmd;
          case (q_cmd.op)
            OP_SHAPE: begin
              if (phase_r != PH_SHAPE) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_PHASE;
                out_symbol_nxt = '0;
              end else if (!q_cmd.dbit && overflow) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_OVERFLOW;
                out_symbol_nxt = '0;
              end else begin
                state_nxt = ST_SHAPE;
              end
            end
            OP_NAME: begin
              if (phase_r != PH_NAME) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_PHASE;
                out_symbol_nxt = '0;
              end else begin
                state_nxt = ST_NAME;
              end
            end
            OP_CODE: begin
              if (phase_r != PH_RUN) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_PHASE;
                out_symbol_nxt = '0;
              end else if (cur_r[NODE_W-1]) begin
                // single-leaf tree: the root is the leaf
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_DECODED;
                out_symbol_nxt = cur_r[NODE_W-2 -: SYM_W];
              end else begin
                state_nxt = ST_CODE;
              end
            end
            default: begin
              phase_nxt        = PH_SHAPE;
              node_count_nxt   = '0;
              pending_nxt      = CNT_W'(1);
              leaf_count_nxt   = '0;
              leaves_named_nxt = '0;
              prev_leaf_nxt    = 1'b0;
            end
          endcase
        end
      end

      ST_SHAPE: begin
        // place the node and link it to its parent
        info_we = 1'b1;
        if (node_count_r != '0) begin
          if (prev_leaf_r) begin
            right_we = 1'b1;
          end else begin
            left_we = 1'b1;
          end
        end
        if (cmd_r.dbit) begin
          list_we        = 1'b1;
          leaf_count_nxt = leaf_count_r + 1'b1;
          pending_nxt    = pending_r - 1'b1;
          if (pending_r == CNT_W'(1)) begin
            phase_nxt = PH_NAME;
          end
        end else begin
          stack_we    = 1'b1;
          pending_nxt = pending_r + 1'b1;
        end
        node_count_nxt = node_count_r + 1'b1;
        prev_leaf_nxt  = cmd_r.dbit;
        state_nxt      = ST_IDLE;
      end

      ST_NAME: begin
        info_we          = 1'b1;
        info_waddr       = list_rdata;
        info_wdata       = {1'b1, cmd_r.sym};
        leaves_named_nxt = leaves_named_r + 1'b1;
        if (LCW'(leaves_named_r + 1'b1) >= leaf_count_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_LOADED;
          out_symbol_nxt = '0;
          phase_nxt      = PH_RUN;
          state_nxt      = ST_ROOT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_ROOT: begin
        state_nxt = ST_LOAD;
      end

      ST_LOAD: begin
        cur_nxt   = node_rdata;
        root_nxt  = node_rdata;
        state_nxt = ST_IDLE;
      end

      ST_CODE: begin
        if (info_rdata[SYM_W]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DECODED;
          out_symbol_nxt = info_rdata[SYM_W-1:0];
          cur_nxt        = root_r;
        end else begin
          cur_nxt = node_rdata;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      phase_r        <= PH_SHAPE;
      node_count_r   <= '0;
      pending_r      <= CNT_W'(1);
      leaf_count_r   <= '0;
      leaves_named_r <= '0;
      prev_leaf_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      node_count_r   <= node_count_nxt;
      pending_r      <= pending_nxt;
      leaf_count_r   <= leaf_count_nxt;
      leaves_named_r <= leaves_named_nxt;
      prev_leaf_r    <= prev_leaf_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    cur_r        <= cur_nxt;
    root_r       <= root_nxt;
    out_status_r <= out_status_nxt;
    out_symbol_r <= out_symbol_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {8'h00, out_symbol_r};

  // node table split into leaf info, left child and right child
  htld_ram #(.WIDTH(INFO_W), .DEPTH(NODE_DEPTH)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .raddr (node_raddr),
    .rdata (info_rdata)
  );

  htld_ram #(.WIDTH(NW), .DEPTH(NODE_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (left_we),
    .waddr (left_waddr),
    .wdata (new_node),
    .raddr (node_raddr),
    .rdata (left_rdata)
  );

  htld_ram #(.WIDTH(NW), .DEPTH(NODE_DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (right_we),
    .waddr (right_waddr),
    .wdata (new_node),
    .raddr (node_raddr),
    .rdata (right_rdata)
  );

  // internal nodes still waiting for a right child
  htld_ram #(.WIDTH(NW), .DEPTH(MAX_SYMBOLS)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_addr),
    .wdata (new_node),
    .raddr (stack_addr),
    .rdata (stack_rdata)
  );

  // node index of each leaf in preorder
  htld_ram #(.WIDTH(NW), .DEPTH(MAX_SYMBOLS)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (new_node),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

endmodule

// ===== hw/rtl/huffman_tree_load_and_decode_core.sv =====
// huffman_tree_load_and_decode_core: Huffman decoder with in-band preorder tree.
// Transactions pass a two-entry queue to the back end. A code bit reads the node table and
// then steps; a single-leaf tree decodes without the read. An item is taken only while the
// back end is idle and the result register free; shape and leaf items pass their own state,
// the last leaf then ROOT and LOAD; refusals and single-leaf decodes are registered on take.
// Reset is synchronous, active low, clears control state only; tables are never cleared.
module huffman_tree_load_and_decode_core import htld_pkg::*; #(
  parameter int MAX_SYMBOLS = 256,
  parameter int NODE_DEPTH  = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] shape_bit, [8:1] leaf_symbol, [9] code_bit
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] symbol
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // front end: classify and queue
  htld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  // back end: tree build, naming and decode
  htld_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .NODE_DEPTH  (NODE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/htld_checker.sv =====
// htld_checker: port-level assertions for the tree load and decode core,
// bound to the top level. Depends on htld_pkg.
module htld_checker import htld_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // only a decoded symbol carries a nonzero byte
  a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_DECODED |-> out_tdata == 16'h0000)
    else $error("symbol nonzero on a status result");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // reset empties the input queue
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind huffman_tree_load_and_decode_core htld_checker u_htld_checker (.*);

// ===== verif/testbench.sv =====
// testbench: self-checking bench for huffman_tree_load_and_decode_core.
// Depends on htld_pkg and the core; drives preorder tree loads, leaf names and code bits,
// and checks every result against a built-in tree walker.
`timescale 1ns / 100ps

module testbench import htld_pkg::*; ();

  localparam int MAX_SYMBOLS  = 256;
  localparam int NODE_DEPTH   = 512;
  localparam int RANDOM_ITEMS = 420;
  localparam int LIMIT_CYCLES = 800000;

  // one input transaction, fields as the stream carries them
  typedef struct packed {
    logic [1:0] kind;
    logic       shape_bit;
    logic [7:0] symbol;
    logic       code_bit;
  } huff_item_t;

  // one predicted result transaction
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] symbol;
  } answer_t;

  typedef enum logic [1:0] {STAGE_SHAPE, STAGE_NAMES, STAGE_DECODE} stage_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  huffman_tree_load_and_decode_core #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .NODE_DEPTH (NODE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow copy of the tree and the loader/walker state
  logic [26:0] node_mem [NODE_DEPTH];
  logic [8:0]  open_stack [MAX_SYMBOLS];
  logic [8:0]  leaf_pos [MAX_SYMBOLS];
  int          nodes_used;
  int          leaves_used;
  int          leaves_labeled;
  int          slots_open;
  stage_t      tree_stage;
  logic [8:0]  walk_at;

  huff_item_t  stim_q [$];
  answer_t     pending_answers [$];
  huff_item_t  drv_item;
  int unsigned gap_left;
  int unsigned ready_hold;
  int          items_sent;
  int          fail_count;
  int          seen_status [4];
  logic [31:0] cycle_count = '0;
  wire         calm = (cycle_count[12:11] == 2'b00);

  function automatic void clear_tree();
    foreach (node_mem[i]) node_mem[i] = '0;
    foreach (open_stack[i]) open_stack[i] = '0;
    foreach (leaf_pos[i]) leaf_pos[i] = '0;
    nodes_used     = 0;
    leaves_used    = 0;
    leaves_labeled = 0;
    slots_open     = 1;
    tree_stage     = STAGE_SHAPE;
    walk_at        = '0;
  endfunction

  // advance the shadow tree by one transaction, report the result it causes
  task automatic walk_and_load(input huff_item_t it, output bit produced, output answer_t res);
    logic [8:0]  n;
    logic [8:0]  par;
    logic [8:0]  nxt;
    logic [26:0] cur;
    produced = 1'b0;
    res = '{status: STAT_DECODED, symbol: 8'h00};
    case (it.kind)
      OP_SHAPE: begin
        if (tree_stage != STAGE_SHAPE) begin
          produced = 1'b1;
          res.status = STAT_PHASE;
        end else if (!it.shape_bit && (nodes_used + slots_open + 2 > NODE_DEPTH ||
                                       leaves_used + slots_open + 1 > MAX_SYMBOLS)) begin
          produced = 1'b1;
          res.status = STAT_OVERFLOW;
        end else begin
          n = nodes_used[8:0];
          // hook the new node under its parent
          if (nodes_used > 0) begin
            if (!node_mem[n - 9'd1][26]) begin
              node_mem[n - 9'd1][17:9] = n;
            end else begin
              par = open_stack[(slots_open - 1) & 255];
              node_mem[par][8:0] = n;
            end
          end
          if (it.shape_bit) begin
            node_mem[n] = {1'b1, 26'd0};
            leaf_pos[leaves_used & 255] = n;
            leaves_used++;
            slots_open--;
          end else begin
            node_mem[n] = '0;
            open_stack[(slots_open - 1) & 255] = n;
            slots_open++;
          end
          nodes_used++;
          if (slots_open == 0) tree_stage = STAGE_NAMES;
        end
      end
      OP_NAME: begin
        if (tree_stage != STAGE_NAMES) begin
          produced = 1'b1;
          res.status = STAT_PHASE;
        end else begin
          n = leaf_pos[leaves_labeled & 255];
          node_mem[n] = {1'b1, it.symbol, 18'd0};
          leaves_labeled++;
          if (leaves_labeled >= leaves_used) begin
            tree_stage = STAGE_DECODE;
            walk_at = '0;
            produced = 1'b1;
            res.status = STAT_LOADED;
          end
        end
      end
      OP_CODE: begin
        if (tree_stage != STAGE_DECODE) begin
          produced = 1'b1;
          res.status = STAT_PHASE;
        end else begin
          cur = node_mem[walk_at];
          if (cur[26]) begin
            // single-leaf tree: the root itself is the symbol
            walk_at = '0;
            produced = 1'b1;
            res.symbol = cur[25:18];
          end else begin
            nxt = it.code_bit ? cur[8:0] : cur[17:9];
            cur = node_mem[nxt];
            if (cur[26]) begin
              walk_at = '0;
              produced = 1'b1;
              res.symbol = cur[25:18];
            end else begin
              walk_at = nxt;
            end
          end
        end
      end
      default: clear_tree();
    endcase
  endtask

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // queue one item; fields the kind does not use get random values
  task automatic add_item(input logic [1:0] kind, input logic bitv, input logic [7:0] sym);
    huff_item_t it;
    it.kind      = kind;
    it.shape_bit = 1'($urandom);
    it.symbol    = 8'($urandom);
    it.code_bit  = 1'($urandom);
    case (kind)
      OP_SHAPE: it.shape_bit = bitv;
      OP_NAME:  it.symbol = sym;
      OP_CODE:  it.code_bit = bitv;
      default: ;
    endcase
    stim_q.insert(stim_q.size(), it);
  endtask

  // now and then slip in a transaction that does not belong to the current stage
  task automatic maybe_noise(input logic [1:0] ok_kind);
    logic k;
    logic [1:0] kind;
    if ($urandom_range(0, 15) != 0) return;
    k = 1'($urandom);
    case (ok_kind)
      OP_SHAPE: kind = k ? OP_CODE : OP_NAME;
      OP_NAME:  kind = k ? OP_CODE : OP_SHAPE;
      default:  kind = k ? OP_NAME : OP_SHAPE;
    endcase
    add_item(kind, 1'($urandom), pick_symbol());
  endtask

  // random full binary tree in preorder, optionally cut short after some bits
  task automatic add_tree(input int leaves, input int cut);
    int   inner_left;
    int   open;
    int   emitted;
    logic leaf;
    inner_left = leaves - 1;
    open = 1;
    emitted = 0;
    while (open > 0 && emitted != cut) begin
      if (inner_left == 0) leaf = 1'b1;
      else if (open == 1) leaf = 1'b0;
      else leaf = 1'($urandom);
      maybe_noise(OP_SHAPE);
      add_item(OP_SHAPE, leaf, 8'h00);
      if (leaf) begin
        open--;
      end else begin
        open++;
        inner_left--;
      end
      emitted++;
    end
  endtask

  // clear, load a tree, name it and decode; mode 1 breaks off the shape, mode 2 the names
  task automatic add_session(input int leaves, input int mode);
    int names;
    add_item(OP_CLEAR, 1'b0, 8'h00);
    if (mode == 1) begin
      add_tree(leaves, $urandom_range(0, 2 * leaves - 2));
      return;
    end
    add_tree(leaves, -1);
    names = (mode == 2) ? $urandom_range(0, leaves - 1) : leaves;
    repeat (names) begin
      maybe_noise(OP_NAME);
      add_item(OP_NAME, 1'b0, pick_symbol());
    end
    if (mode == 2) return;
    repeat ($urandom_range(leaves, 4 * leaves + 8)) begin
      maybe_noise(OP_CODE);
      add_item(OP_CODE, 1'($urandom), 8'h00);
    end
  endtask

  // stimulus: directed opening, one overflowing chain, then random sessions
  initial begin
    int target;
    clear_tree();
    // code bit and leaf name before any tree exists
    add_item(OP_CODE, 1'b0, 8'h00);
    add_item(OP_NAME, 1'b0, 8'hFF);
    // single-leaf tree decodes its symbol on every bit
    add_item(OP_SHAPE, 1'b1, 8'h00);
    add_item(OP_SHAPE, 1'b0, 8'h00);
    add_item(OP_NAME, 1'b0, 8'h00);
    add_item(OP_CODE, 1'b0, 8'h00);
    add_item(OP_CODE, 1'b1, 8'h00);
    add_item(OP_NAME, 1'b0, 8'h12);
    add_item(OP_CLEAR, 1'b0, 8'h00);
    // three leaves: internal(internal(leaf, leaf), leaf)
    add_item(OP_SHAPE, 1'b0, 8'h00);
    add_item(OP_SHAPE, 1'b0, 8'h00);
    add_item(OP_SHAPE, 1'b1, 8'h00);
    add_item(OP_SHAPE, 1'b1, 8'h00);
    add_item(OP_SHAPE, 1'b1, 8'h00);
    add_item(OP_SHAPE, 1'b0, 8'h00);
    add_item(OP_NAME, 1'b0, 8'h00);
    add_item(OP_NAME, 1'b0, 8'hFF);
    add_item(OP_NAME, 1'b0, 8'hA5);
    add_item(OP_CODE, 1'b0, 8'h00);
    add_item(OP_CODE, 1'b0, 8'h00);
    add_item(OP_CODE, 1'b0, 8'h00);
    add_item(OP_CODE, 1'b1, 8'h00);
    add_item(OP_CODE, 1'b1, 8'h00);
    add_item(OP_CODE, 1'b1, 8'h00);
    add_item(OP_CLEAR, 1'b0, 8'h00);

    // left-leaning chain of internal nodes that runs into overflow, then abandoned
    add_item(OP_CLEAR, 1'b0, 8'h00);
    repeat (MAX_SYMBOLS + 2) add_item(OP_SHAPE, 1'b0, 8'h00);

    // random sessions, mostly small trees, some broken off
    target = stim_q.size() + RANDOM_ITEMS;
    while (stim_q.size() < target) begin
      int unsigned r;
      r = $urandom_range(0, 99);
      add_session(($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8),
                  (r < 8) ? 1 : (r < 16) ? 2 : 0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all items accepted, all results seen, then a short settle
    while (stim_q.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("loaded/decoded with %0d input transactions: %0d symbols, %0d out-of-phase,",
             items_sent, seen_status[STAT_DECODED], seen_status[STAT_PHASE]);
    $display("  %0d overflow refusals, %0d trees loaded, %0d mismatches",
             seen_status[STAT_OVERFLOW], seen_status[STAT_LOADED], fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // input driver: predicts on each accepted transaction, then launches the next
  always @(posedge clk) begin : drive_proc
    bit      made;
    answer_t ans;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        walk_and_load(drv_item, made, ans);
        if (made) pending_answers.insert(pending_answers.size(), ans);
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          drv_item = stim_q.pop_front();
          in_tdata <= {6'd0, drv_item.code_bit, drv_item.symbol, drv_item.shape_bit};
          in_tuser <= drv_item.kind;
          in_tvalid <= 1'b1;
          gap_left = calm ? 0 : pick_pause();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : monitor_proc
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen_status[out_tuser]++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d symbol %02h",
                 $time, out_tuser, out_tdata);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, out_tuser);
          fail_count++;
        end
        if (out_tdata !== {8'h00, want.symbol}) begin
          $display("%0t: symbol mismatch, expected %04h, got %04h",
                   $time, {8'h00, want.symbol}, out_tdata);
          fail_count++;
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      ready_hold = pick_pause();
      if (ready_hold > 0) begin
        ready_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_answers.size());
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/htld_pkg.sv
hw/rtl/htld_ram.sv
hw/rtl/htld_front.sv
hw/rtl/htld_back.sv
hw/rtl/huffman_tree_load_and_decode_core.sv
hw/rtl/htld_checker.sv
verif/testbench.sv
